// File: rtl/core/cntsem_pkg.sv
package cntsem_pkg;

  // Default queue depth, one slot per task
  localparam int unsigned TaskSlotsDefault = 16;

  localparam int unsigned CountW  = 16;
  localparam int unsigned TaskW   = 4;
  localparam int unsigned WStateW = 4;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    ACT_SIGNAL  = 2'd0,
    ACT_WAIT    = 2'd1,
    ACT_TRYWAIT = 2'd2,
    ACT_READ    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_RAISED  = 3'd0,
    ST_WOKEN   = 3'd1,
    ST_GRANTED = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_TRYFAIL = 3'd4,
    ST_READ    = 3'd5
  } status_e;

endpackage

// File: rtl/core/counting_semaphore_fifo_wait.sv
// Counting semaphore with a FIFO of blocked task ids. A command is taken when
// start is high and busy is low; busy then stays high for one cycle while the
// head entry of the wait queue, read from a registered-read memory at the
// accept edge, is used to update count, pointers and queue. The result shows
// on the result ports with done_o for exactly one cycle, the cycle after that,
// and cannot be held off: capture it when done_o is high. A new command may be
// issued in that same cycle, but none is taken while one still executes, since
// each needs the queue memory read followed by the update. Writing cfg_data_i
// loads the count at once and leaves the queue untouched; cfg_ready_o is low
// while a command executes, and writes belong where no command is in flight.
module counting_semaphore_fifo_wait #(
  parameter int unsigned TASK_SLOTS = cntsem_pkg::TaskSlotsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     action_i,
  input  logic [cntsem_pkg::TaskW-1:0]   task_id_i,
  input  logic [cntsem_pkg::WStateW-1:0] wait_state_i,
  // result channel
  output logic                           done_o,
  output logic [2:0]                     status_o,
  output logic [cntsem_pkg::TaskW-1:0]   woken_task_o,
  output logic [cntsem_pkg::WStateW-1:0] blocked_state_o,
  output logic [cntsem_pkg::CountW-1:0]  count_value_o,
  output logic                           error_o,
  // initial count write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cntsem_pkg::CountW-1:0]  cfg_data_i
);

  localparam int unsigned PtrW  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned FillW = $clog2(TASK_SLOTS + 1);
  localparam logic [PtrW-1:0]  PtrLast  = PtrW'(TASK_SLOTS - 1);
  localparam logic [FillW-1:0] FillFull = FillW'(TASK_SLOTS);

  typedef enum logic {
    IDLE,
    EXEC
  } state_e;

  state_e                           state_q;
  cntsem_pkg::action_e              act_q;
  logic [cntsem_pkg::TaskW-1:0]     task_q;
  logic [cntsem_pkg::WStateW-1:0]   wstate_q;
  logic [cntsem_pkg::CountW-1:0]    count_q, count_d;
  logic [PtrW-1:0]                  head_q, head_d;
  logic [PtrW-1:0]                  tail_q, tail_d;
  logic [FillW-1:0]                 fill_q, fill_d;

  cntsem_pkg::status_e              status_d, status_q;
  logic [cntsem_pkg::TaskW-1:0]     woken_d, woken_q;
  logic [cntsem_pkg::WStateW-1:0]   bstate_d, bstate_q;
  logic                             err_d, err_q;
  logic                             done_q;
  logic                             push;

  // wait queue memory, registered read of the head entry
  logic [cntsem_pkg::TaskW-1:0]     queue_mem [TASK_SLOTS];
  logic [cntsem_pkg::TaskW-1:0]     rd_data_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_mem[tail_q] <= task_q;
    end
    rd_data_q <= queue_mem[head_q];
  end

  // action decode and update of count and queue pointers
  always_comb begin
    count_d  = count_q;
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    status_d = cntsem_pkg::ST_READ;
    woken_d  = '0;
    bstate_d = '0;
    err_d    = 1'b0;
    push     = 1'b0;
    unique case (act_q)
      cntsem_pkg::ACT_SIGNAL: begin
        if (fill_q != '0) begin
          woken_d  = rd_data_q;
          head_d   = (head_q == PtrLast) ? '0 : head_q + PtrW'(1);
          fill_d   = fill_q - FillW'(1);
          status_d = cntsem_pkg::ST_WOKEN;
        end else begin
          status_d = cntsem_pkg::ST_RAISED;
          if (count_q == cntsem_pkg::CountMax) begin
            err_d = 1'b1;
          end else begin
            count_d = count_q + cntsem_pkg::CountW'(1);
          end
        end
      end
      cntsem_pkg::ACT_WAIT: begin
        if (count_q != '0) begin
          count_d  = count_q - cntsem_pkg::CountW'(1);
          status_d = cntsem_pkg::ST_GRANTED;
        end else begin
          status_d = cntsem_pkg::ST_BLOCKED;
          if (fill_q == FillFull) begin
            err_d = 1'b1;
          end else begin
            push     = (state_q == EXEC);
            tail_d   = (tail_q == PtrLast) ? '0 : tail_q + PtrW'(1);
            fill_d   = fill_q + FillW'(1);
            bstate_d = wstate_q;
          end
        end
      end
      cntsem_pkg::ACT_TRYWAIT: begin
        if (count_q != '0) begin
          count_d  = count_q - cntsem_pkg::CountW'(1);
          status_d = cntsem_pkg::ST_GRANTED;
        end else begin
          status_d = cntsem_pkg::ST_TRYFAIL;
        end
      end
      cntsem_pkg::ACT_READ: begin
        status_d = cntsem_pkg::ST_READ;
      end
      default: begin
        status_d = cntsem_pkg::ST_READ;
      end
    endcase
  end

  // control state machine with registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= IDLE;
      act_q    <= cntsem_pkg::ACT_READ;
      task_q   <= '0;
      wstate_q <= '0;
      count_q  <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      status_q <= cntsem_pkg::ST_READ;
      woken_q  <= '0;
      bstate_q <= '0;
      err_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        IDLE: begin
          if (start) begin
            act_q    <= cntsem_pkg::action_e'(action_i);
            task_q   <= task_id_i;
            wstate_q <= wait_state_i;
            state_q  <= EXEC;
          end
        end
        EXEC: begin
          count_q  <= count_d;
          head_q   <= head_d;
          tail_q   <= tail_d;
          fill_q   <= fill_d;
          status_q <= status_d;
          woken_q  <= woken_d;
          bstate_q <= bstate_d;
          err_q    <= err_d;
          done_q   <= 1'b1;
          state_q  <= IDLE;
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
      // initial count write loads the count directly, only while idle
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  assign busy            = (state_q == EXEC);
  assign cfg_ready_o     = (state_q == IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign woken_task_o    = woken_q;
  assign blocked_state_o = bstate_q;
  assign count_value_o   = count_q;
  assign error_o         = err_q;

  // a result only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a command in flight");

  // queue fill never exceeds the depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("wait queue overfilled");

  // a woken task always pops one entry
  a_wake_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == cntsem_pkg::ST_WOKEN) |->
      (fill_q == $past(fill_q) - FillW'(1)))
    else $error("wake without queue pop");

  // a blocked wait flagged as error only when the queue is full
  a_block_err_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && error_o && status_o == cntsem_pkg::ST_BLOCKED) |->
      (fill_q == FillFull))
    else $error("queue-full error with room left");

endmodule
